// ----- rtl/scfd_pkg.sv -----
// Package for the summed constant fraction discriminator: field widths,
// register indexes, the pipeline control type and the scale-and-clip function.
// Depends on nothing.
package scfd_pkg;

   localparam int LANES       = 4;
   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int LEVEL_W     = 24;
   localparam int ATTEN_W     = 16;
   localparam int DELAY_W     = 7;
   localparam int MASK_W      = 4;
   localparam int FIELD_W     = 10;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;
   localparam int SIG_W       = 26;
   localparam int CFD_W       = 32;
   localparam int PROD_W      = LEVEL_W + ATTEN_W + 1;
   localparam int ATTEN_SHIFT = 12;

   localparam logic [FIELD_W-1:0] COUNT_MAX = 10'd1023;

   localparam logic [CSR_INDEX_W-1:0] REG_GAIN        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CLIP_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CLIP_LEVEL  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTENUATION = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_DELAY       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CFD_ENABLE  = 3'd6;

   typedef struct packed {
      logic               valid;
      logic               start;
      logic               last;
      logic               past_delay;
      logic [MASK_W-1:0]  mask;
      logic [FIELD_W-1:0] group;
   } ctl_type;

   // Scales a raw sample by the Q8.8 gain, rounding towards minus infinity,
   // and clips it from below when clipping is enabled.
   function automatic logic signed [LEVEL_W-1:0] scale_clip(
      input logic signed [SAMPLE_W-1:0] raw,
      input logic [GAIN_W-1:0]          gain,
      input logic                       clip_en,
      input logic signed [LEVEL_W-1:0]  level);
      logic signed [SAMPLE_W+GAIN_W:0] prod;
      logic signed [LEVEL_W-1:0]       v;
      prod = raw * $signed({1'b0, gain});
      v = $signed(prod[LEVEL_W+7:8]);
      if (clip_en && (v < level)) begin
         v = level;
      end
      return v;
   endfunction

endpackage

// ----- rtl/summed_cfd_leading_edge_discriminator_unit.sv -----
// Summed-group constant fraction / leading edge discriminator, top level.
// Depends on scfd_pkg for widths, register indexes and the scaling function.
//
// Usage: each item on the req_ channel is one time sample of up to four member
// lanes of one trigger group. Traces start with req_first_sample or after the
// previous trace ended; the item with req_last_sample produces one result on
// the rsp_ channel (fired flag, firing sample index, samples over threshold).
// Settings are written through the csr_ port while the block is idle.
// Throughput is one item per cycle while req_ready is high, set by a four-stage
// pipeline around a single delay memory that is written once per item and read
// every cycle. A result passes through stages A, B and C into the output
// register. After a last item, req_ready stays low until that item has reached
// the output register, and while a result waits there with rsp_ready low no
// further item is taken. The delay memory needs no clearing: an entry is only
// used after the current trace has written it. Reset restores the register
// defaults, empties the pipeline and starts a new trace.
module summed_cfd_leading_edge_discriminator_unit #(
   parameter int MEMBERS     = 4,
   parameter int MAX_DELAY   = 64,
   parameter int MAX_SAMPLES = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [scfd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [scfd_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [scfd_pkg::FIELD_W-1:0]          req_group_id,
   input  logic [scfd_pkg::MASK_W-1:0]           req_member_mask,
   input  logic signed [scfd_pkg::SAMPLE_W-1:0]  req_member_sample_0,
   input  logic signed [scfd_pkg::SAMPLE_W-1:0]  req_member_sample_1,
   input  logic signed [scfd_pkg::SAMPLE_W-1:0]  req_member_sample_2,
   input  logic signed [scfd_pkg::SAMPLE_W-1:0]  req_member_sample_3,
   input  logic                                  req_first_sample,
   input  logic                                  req_last_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [scfd_pkg::FIELD_W-1:0]          rsp_group_out,
   output logic                                  rsp_fired,
   output logic [scfd_pkg::FIELD_W-1:0]          rsp_fire_index,
   output logic [scfd_pkg::FIELD_W-1:0]          rsp_over_threshold_count
);

   localparam int NL     = (MEMBERS < scfd_pkg::LANES) ? MEMBERS : scfd_pkg::LANES;
   localparam int SW     = $clog2(MAX_DELAY);
   localparam int DW     = $clog2(MAX_DELAY + 1);
   localparam int IW     = $clog2(MAX_SAMPLES);
   localparam int PW     = SW + 2;
   localparam int CW     = ((IW > DW) ? IW : DW) + 1;
   localparam int XW     = IW + scfd_pkg::FIELD_W;
   localparam int ROW_W  = NL * scfd_pkg::SAMPLE_W;
   localparam int SMP_W  = scfd_pkg::SAMPLE_W;
   localparam int LVL_W  = scfd_pkg::LEVEL_W;
   localparam int SIG_W  = scfd_pkg::SIG_W;
   localparam int CFD_W  = scfd_pkg::CFD_W;
   localparam int PROD_W = scfd_pkg::PROD_W;
   localparam int FW     = scfd_pkg::FIELD_W;

   // Settings.
   logic [scfd_pkg::GAIN_W-1:0]  gain_ff;
   logic                         clip_en_ff;
   logic signed [LVL_W-1:0]      clip_level_ff;
   logic [scfd_pkg::ATTEN_W-1:0] atten_ff;
   logic [scfd_pkg::DELAY_W-1:0] delay_ff;
   logic signed [LVL_W-1:0]      threshold_ff;
   logic                         cfd_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= 16'd256;
         clip_en_ff    <= 1'b0;
         clip_level_ff <= 24'sh800000;
         atten_ff      <= 16'd1638;
         delay_ff      <= 7'd1;
         threshold_ff  <= 24'shFFF600;
         cfd_en_ff     <= 1'b1;
      end else if (csr_wr_en) begin
         case (csr_index)
            scfd_pkg::REG_GAIN: begin
               gain_ff <= csr_wr_data[scfd_pkg::GAIN_W-1:0];
            end
            scfd_pkg::REG_CLIP_ENABLE: begin
               clip_en_ff <= csr_wr_data[0];
            end
            scfd_pkg::REG_CLIP_LEVEL: begin
               clip_level_ff <= $signed(csr_wr_data[LVL_W-1:0]);
            end
            scfd_pkg::REG_ATTENUATION: begin
               atten_ff <= csr_wr_data[scfd_pkg::ATTEN_W-1:0];
            end
            scfd_pkg::REG_DELAY: begin
               delay_ff <= csr_wr_data[scfd_pkg::DELAY_W-1:0];
            end
            scfd_pkg::REG_THRESHOLD: begin
               threshold_ff <= $signed(csr_wr_data[LVL_W-1:0]);
            end
            scfd_pkg::REG_CFD_ENABLE: begin
               cfd_en_ff <= csr_wr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Input side: trace position, delay slot and stand-in values.
   logic signed [SMP_W-1:0] raw [scfd_pkg::LANES];
   logic [IW-1:0]           index_ff, index_in, idx_cur;
   logic [SW-1:0]           slot_ff, slot_in, slot_cur, old_slot;
   logic signed [SMP_W-1:0] first_ff [NL];
   logic signed [SMP_W-1:0] first_in [NL];
   logic signed [SMP_W-1:0] stand [NL];
   logic [ROW_W-1:0]        row_in, rd_row_ff;
   logic [ROW_W-1:0]        delay_mem [MAX_DELAY];
   logic [8:0]              d_wide;
   logic [DW-1:0]           d_clamp;
   logic [PW-1:0]           slot_diff;
   logic                    accept, is_start, past_delay;
   logic                    rsp_valid_ff, rsp_valid_in;

   scfd_pkg::ctl_type a_ctl_ff, a_ctl_in, b_ctl_ff, c_ctl_ff;
   logic [IW-1:0]     a_idx_ff, b_idx_ff, c_idx_ff;

   assign raw[0] = req_member_sample_0;
   assign raw[1] = req_member_sample_1;
   assign raw[2] = req_member_sample_2;
   assign raw[3] = req_member_sample_3;

   assign req_ready = !(a_ctl_ff.valid && a_ctl_ff.last) &&
                      !(b_ctl_ff.valid && b_ctl_ff.last) &&
                      !(c_ctl_ff.valid && c_ctl_ff.last) &&
                      !(rsp_valid_ff && !rsp_ready);
   assign accept = req_valid && req_ready;

   always_comb begin
      idx_cur  = req_first_sample ? '0 : index_ff;
      is_start = (idx_cur == '0);
      slot_cur = is_start ? '0 : slot_ff;

      d_wide = {2'b00, delay_ff};
      if (d_wide == 9'd0) begin
         d_clamp = DW'(1);
      end else if (d_wide > 9'(MAX_DELAY)) begin
         d_clamp = DW'(MAX_DELAY);
      end else begin
         d_clamp = DW'(d_wide);
      end
      past_delay = (CW'(idx_cur) >= CW'(d_clamp));

      slot_diff = PW'(slot_cur) + PW'(MAX_DELAY) - PW'(d_clamp);
      if (slot_diff >= PW'(MAX_DELAY)) begin
         slot_diff = slot_diff - PW'(MAX_DELAY);
      end
      old_slot = slot_diff[SW-1:0];

      index_in = index_ff;
      slot_in  = slot_ff;
      if (accept) begin
         if (req_last_sample || (idx_cur == IW'(MAX_SAMPLES - 1))) begin
            index_in = '0;
         end else begin
            index_in = idx_cur + 1'b1;
         end
         if (req_last_sample || (slot_cur == SW'(MAX_DELAY - 1))) begin
            slot_in = '0;
         end else begin
            slot_in = slot_cur + 1'b1;
         end
      end

      for (int k = 0; k < NL; k++) begin
         row_in[k*SMP_W +: SMP_W] = raw[k];
         stand[k]    = is_start ? raw[k] : first_ff[k];
         first_in[k] = (accept && is_start) ? raw[k] : first_ff[k];
      end

      a_ctl_in.valid      = accept;
      a_ctl_in.start      = is_start;
      a_ctl_in.last       = req_last_sample;
      a_ctl_in.past_delay = past_delay;
      a_ctl_in.mask       = req_member_mask;
      a_ctl_in.group      = req_group_id;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         delay_mem[slot_cur] <= row_in;
      end
      rd_row_ff <= delay_mem[old_slot];
   end

   // Stage A: raw samples and stand-ins, delayed row arriving from memory.
   logic signed [SMP_W-1:0] a_raw_ff [NL];
   logic signed [SMP_W-1:0] a_stand_ff [NL];

   always_ff @(posedge clock) begin
      for (int k = 0; k < NL; k++) begin
         a_raw_ff[k]   <= raw[k];
         a_stand_ff[k] <= stand[k];
      end
      a_idx_ff <= idx_cur;
   end

   // Stage B: scaled present and delayed member values.
   logic signed [SMP_W-1:0] dly_raw [NL];
   logic signed [LVL_W-1:0] b_scaled_in [NL];
   logic signed [LVL_W-1:0] b_delayed_in [NL];
   logic signed [LVL_W-1:0] b_scaled_ff [NL];
   logic signed [LVL_W-1:0] b_delayed_ff [NL];

   always_comb begin
      for (int k = 0; k < NL; k++) begin
         dly_raw[k] = a_ctl_ff.past_delay ? $signed(rd_row_ff[k*SMP_W +: SMP_W])
                                          : a_stand_ff[k];
         if (a_ctl_ff.mask[k]) begin
            b_scaled_in[k]  = scfd_pkg::scale_clip(a_raw_ff[k], gain_ff, clip_en_ff,
                                                   clip_level_ff);
            b_delayed_in[k] = scfd_pkg::scale_clip(dly_raw[k], gain_ff, clip_en_ff,
                                                   clip_level_ff);
         end else begin
            b_scaled_in[k]  = '0;
            b_delayed_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NL; k++) begin
         b_scaled_ff[k]  <= b_scaled_in[k];
         b_delayed_ff[k] <= b_delayed_in[k];
      end
      b_idx_ff <= a_idx_ff;
   end

   // Stage C: group signal and CFD sum.
   logic signed [PROD_W-1:0] prod_b [NL];
   logic signed [CFD_W-1:0]  term [NL];
   logic signed [SIG_W-1:0]  c_sig_ff, c_sig_in;
   logic signed [CFD_W-1:0]  c_cfd_ff, c_cfd_in;

   always_comb begin
      c_sig_in = '0;
      c_cfd_in = '0;
      for (int k = 0; k < NL; k++) begin
         prod_b[k] = b_scaled_ff[k] * $signed({1'b0, atten_ff});
         term[k]   = CFD_W'($signed(prod_b[k][PROD_W-1:scfd_pkg::ATTEN_SHIFT]))
                     - CFD_W'(b_delayed_ff[k]);
         c_sig_in  = c_sig_in + SIG_W'(b_scaled_ff[k]);
         c_cfd_in  = c_cfd_in + term[k];
      end
   end

   always_ff @(posedge clock) begin
      c_sig_ff <= c_sig_in;
      c_cfd_ff <= c_cfd_in;
      c_idx_ff <= b_idx_ff;
   end

   // Decision: trigger state and time over threshold.
   logic          fired_ff, fired_in, counting_ff, counting_in;
   logic [FW-1:0] pos_ff, pos_in, count_ff, count_in;
   logic [XW-1:0] idx_ext;
   logic          below, cfd_ok;
   logic [FW-1:0] rsp_group_ff, rsp_group_in, rsp_index_ff, rsp_index_in;
   logic [FW-1:0] rsp_count_ff, rsp_count_in;
   logic          rsp_fired_ff, rsp_fired_in;

   always_comb begin
      idx_ext = XW'(c_idx_ff);
      below   = (c_sig_ff <= SIG_W'(threshold_ff));
      cfd_ok  = !cfd_en_ff || !c_cfd_ff[CFD_W-1];

      fired_in    = fired_ff;
      counting_in = counting_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      if (c_ctl_ff.valid) begin
         if (c_ctl_ff.start) begin
            fired_in    = 1'b0;
            counting_in = 1'b0;
            pos_in      = '0;
            count_in    = '0;
         end
         if (counting_in) begin
            if (c_ctl_ff.last || !below) begin
               counting_in = 1'b0;
            end else if (count_in < scfd_pkg::COUNT_MAX) begin
               count_in = count_in + 1'b1;
            end
         end else if (!fired_in && c_ctl_ff.past_delay && below && cfd_ok) begin
            fired_in = 1'b1;
            pos_in   = idx_ext[FW-1:0];
            if (!c_ctl_ff.last) begin
               count_in    = FW'(1);
               counting_in = 1'b1;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_group_in = rsp_group_ff;
      rsp_fired_in = rsp_fired_ff;
      rsp_index_in = rsp_index_ff;
      rsp_count_in = rsp_count_ff;
      if (c_ctl_ff.valid && c_ctl_ff.last) begin
         rsp_valid_in = 1'b1;
         rsp_group_in = c_ctl_ff.group;
         rsp_fired_in = fired_in;
         rsp_index_in = fired_in ? pos_in : '0;
         rsp_count_in = fired_in ? count_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= '0;
         slot_ff      <= '0;
         a_ctl_ff     <= '0;
         b_ctl_ff     <= '0;
         c_ctl_ff     <= '0;
         fired_ff     <= 1'b0;
         counting_ff  <= 1'b0;
         pos_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < NL; k++) begin
            first_ff[k] <= '0;
         end
      end else begin
         index_ff     <= index_in;
         slot_ff      <= slot_in;
         a_ctl_ff     <= a_ctl_in;
         b_ctl_ff     <= a_ctl_ff;
         c_ctl_ff     <= b_ctl_ff;
         fired_ff     <= fired_in;
         counting_ff  <= counting_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < NL; k++) begin
            first_ff[k] <= first_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_group_ff <= rsp_group_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_group_out            = rsp_group_ff;
   assign rsp_fired                = rsp_fired_ff;
   assign rsp_fire_index           = rsp_index_ff;
   assign rsp_over_threshold_count = rsp_count_ff;

endmodule
